[sv/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[sv/dclc_pkg.sv]
// types, widths and codes for the distance cull / lod classifier
// no dependencies; imported by every other file of the block except assert_macros.svh
`default_nettype none

package dclc_pkg;

  localparam int COORD_BITS = 24;
  localparam int COUNT_BITS = 16;

  // squared distance of three coordinate deltas and its root
  localparam int SQ_W   = 2 * COORD_BITS + 2;
  localparam int ROOT_W = SQ_W / 2;

  localparam int DIST_W     = 25;
  localparam int SUM_W      = 41;
  localparam int OUT_CNT_W  = 16;
  localparam int PCT_W      = 15;
  localparam int PCT_NUM_W  = COUNT_BITS + PCT_W;
  localparam int DIV_W      = SUM_W;
  localparam int CLASS_W    = 3;

  localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [DIST_W-1:0]    DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = {OUT_CNT_W{1'b1}};
  localparam logic [PCT_W-1:0]     PCT_SCALE   = 15'd25600;

  localparam int APB_DATA_W = 32;
  localparam int REG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CAM_X      = 3'd0,
    REG_CAM_Y      = 3'd1,
    REG_CAM_Z      = 3'd2,
    REG_MAX_DIST   = 3'd3,
    REG_HIGH_DIST  = 3'd4,
    REG_MED_DIST   = 3'd5,
    REG_CULL_EN    = 3'd6,
    REG_LOD_EN     = 3'd7
  } reg_idx_t;

  typedef enum logic [CLASS_W-1:0] {
    CLS_VISIBLE = 3'd0,
    CLS_CULLED  = 3'd1,
    CLS_HIGH    = 3'd2,
    CLS_MEDIUM  = 3'd3,
    CLS_LOW     = 3'd4
  } lod_class_t;

  typedef enum logic {
    KIND_OBJECT  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    MUL_X = 2'd0,
    MUL_Y = 2'd1,
    MUL_Z = 2'd2
  } mul_sel_t;

  typedef enum logic {
    DIV_AVG = 1'b0,
    DIV_PCT = 1'b1
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_MUL_X,
    S_MUL_Y,
    S_MUL_Z,
    S_ACC,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_CLASSIFY,
    S_EMIT_OBJ,
    S_AVG_GO,
    S_AVG_WAIT,
    S_PCT_GO,
    S_PCT_WAIT,
    S_EMIT_SUM
  } ctrl_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cam_x;
    logic signed [COORD_BITS-1:0] cam_y;
    logic signed [COORD_BITS-1:0] cam_z;
    logic [DIST_W-1:0]            max_dist;
    logic [DIST_W-1:0]            high_dist;
    logic [DIST_W-1:0]            med_dist;
    logic                         cull_en;
    logic                         lod_en;
  } dclc_cfg_t;

  typedef struct packed {
    logic     load_in;
    logic     diff_en;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     root_start;
    logic     classify;
    logic     obj_write;
    logic     div_start;
    div_sel_t div_sel;
    logic     avg_capture;
    logic     sum_write;
  } dclc_cmd_t;

  typedef struct packed {
    logic present;
    logic eof;
    logic root_done;
    logic div_done;
    logic out_free;
  } dclc_status_t;

endpackage

`default_nettype wire

[sv/dclc_if.sv]
// valid/ready channel interfaces for object words and result words
// depends on dclc_pkg
`default_nettype none

interface dclc_in_if;
  import dclc_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [COORD_BITS-1:0] pos_z;
  logic                         present;
  logic                         end_of_frame;

  modport source (output valid, pos_x, pos_y, pos_z, present, end_of_frame, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, present, end_of_frame, output ready);
endinterface

interface dclc_out_if;
  import dclc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [CLASS_W-1:0]    lod_class;
  logic [DIST_W-1:0]     distance;
  logic [OUT_CNT_W-1:0]  total_count;
  logic [OUT_CNT_W-1:0]  culled_count;
  logic [OUT_CNT_W-1:0]  visible_count;
  logic [OUT_CNT_W-1:0]  high_count;
  logic [OUT_CNT_W-1:0]  medium_count;
  logic [OUT_CNT_W-1:0]  low_count;
  logic [DIST_W-1:0]     average_distance;
  logic [PCT_W-1:0]      culled_percent;
  logic                  last;

  modport source (output valid, kind, lod_class, distance, total_count, culled_count,
                  visible_count, high_count, medium_count, low_count, average_distance,
                  culled_percent, last, input ready);
  modport sink   (input valid, kind, lod_class, distance, total_count, culled_count,
                  visible_count, high_count, medium_count, low_count, average_distance,
                  culled_percent, last, output ready);
endinterface

`default_nettype wire

[sv/dclc_regs.sv]
// apb configuration registers: camera position, distance limits, enables
// depends on dclc_pkg
`default_nettype none

module dclc_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dclc_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [dclc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dclc_pkg::APB_DATA_W-1:0]   prdata,
  output dclc_pkg::dclc_cfg_t               cfg
);
  import dclc_pkg::*;

  logic signed [COORD_BITS-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [DIST_W-1:0]            max_dist_r, high_dist_r, med_dist_r;
  logic                         cull_en_r, lod_en_r;
  logic                         wr_en;
  reg_idx_t                     idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[REG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r     <= '0;
      cam_y_r     <= '0;
      cam_z_r     <= '0;
      max_dist_r  <= DIST_MAX;
      high_dist_r <= '0;
      med_dist_r  <= '0;
      cull_en_r   <= 1'b1;
      lod_en_r    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_CAM_X:     cam_x_r     <= pwdata[COORD_BITS-1:0];
        REG_CAM_Y:     cam_y_r     <= pwdata[COORD_BITS-1:0];
        REG_CAM_Z:     cam_z_r     <= pwdata[COORD_BITS-1:0];
        REG_MAX_DIST:  max_dist_r  <= pwdata[DIST_W-1:0];
        REG_HIGH_DIST: high_dist_r <= pwdata[DIST_W-1:0];
        REG_MED_DIST:  med_dist_r  <= pwdata[DIST_W-1:0];
        REG_CULL_EN:   cull_en_r   <= pwdata[0];
        REG_LOD_EN:    lod_en_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CAM_X:     prdata = APB_DATA_W'(cam_x_r);
      REG_CAM_Y:     prdata = APB_DATA_W'(cam_y_r);
      REG_CAM_Z:     prdata = APB_DATA_W'(cam_z_r);
      REG_MAX_DIST:  prdata = APB_DATA_W'(max_dist_r);
      REG_HIGH_DIST: prdata = APB_DATA_W'(high_dist_r);
      REG_MED_DIST:  prdata = APB_DATA_W'(med_dist_r);
      REG_CULL_EN:   prdata = APB_DATA_W'(cull_en_r);
      REG_LOD_EN:    prdata = APB_DATA_W'(lod_en_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    cfg.cam_x     = cam_x_r;
    cfg.cam_y     = cam_y_r;
    cfg.cam_z     = cam_z_r;
    cfg.max_dist  = max_dist_r;
    cfg.high_dist = high_dist_r;
    cfg.med_dist  = med_dist_r;
    cfg.cull_en   = cull_en_r;
    cfg.lod_en    = lod_en_r;
  end

endmodule

`default_nettype wire

[sv/dclc_sqrt.sv]
// bit-serial integer square root, one root bit per cycle, truncated result
// depends on dclc_pkg
`default_nettype none

module dclc_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dclc_pkg::SQ_W-1:0]   radicand,
  output logic [dclc_pkg::ROOT_W-1:0] root,
  output logic                        done
);
  import dclc_pkg::*;

  logic [SQ_W-1:0]       rad_r;
  logic [ROOT_W:0]       rem_r;
  logic [ROOT_W-1:0]     root_r;
  logic [SQRT_CNT_W-1:0] cnt_r;
  logic                  busy_r, done_r;

  logic [ROOT_W+2:0]     rem_t, trial, diff;
  logic                  ge;

  // bring down two radicand bits, try subtracting 4*root+1
  assign rem_t = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign ge    = rem_t >= trial;
  assign diff  = rem_t - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= SQRT_CNT_W'(ROOT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == SQRT_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= ge ? diff[ROOT_W:0] : rem_t[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

[sv/dclc_div.sv]
// restoring divider, one quotient bit per cycle
// depends on dclc_pkg; a zero divisor gives a meaningless quotient
`default_nettype none

module dclc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dclc_pkg::DIV_W-1:0]      dividend,
  input  logic [dclc_pkg::COUNT_BITS-1:0] divisor,
  output logic [dclc_pkg::DIV_W-1:0]      quotient,
  output logic                            done
);
  import dclc_pkg::*;

  logic [DIV_W-1:0]      quo_r;
  logic [COUNT_BITS-1:0] rem_r, dvs_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r, done_r;

  logic [COUNT_BITS:0]   rem_t, diff;
  logic                  ge;

  assign rem_t = {rem_r, quo_r[DIV_W-1]};
  assign ge    = rem_t >= {1'b0, dvs_r};
  assign diff  = rem_t - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[COUNT_BITS-1:0] : rem_t[COUNT_BITS-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

`default_nettype wire

[sv/dclc_dp.sv]
// datapath: coordinate deltas, squaring, root, classification, frame
// statistics and the output word register; uses dclc_pkg, dclc_if, dclc_sqrt, dclc_div
`default_nettype none
`include "assert_macros.svh"

module dclc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dclc_pkg::dclc_cfg_t                 cfg,
  input  dclc_pkg::dclc_cmd_t                 cmd,
  output dclc_pkg::dclc_status_t              status,
  input  logic signed [dclc_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [dclc_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [dclc_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic                                in_present,
  input  logic                                in_eof,
  dclc_out_if.source                          out_ch
);
  import dclc_pkg::*;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                     input logic signed [COORD_BITS-1:0] b);
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
    return d[COORD_BITS] ? COORD_BITS'(-d) : COORD_BITS'(d);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic logic [DIST_W-1:0] dist_clamp(input logic [ROOT_W-1:0] r);
    logic [63:0] w;
    w = 64'(r);
    return (w > 64'(DIST_MAX)) ? DIST_MAX : w[DIST_W-1:0];
  endfunction

  function automatic logic [OUT_CNT_W-1:0] out_count(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'(OUT_CNT_MAX)) ? OUT_CNT_MAX : w[OUT_CNT_W-1:0];
  endfunction

  // latched object word
  logic signed [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic                         present_r, eof_r;

  // squared distance
  logic [COORD_BITS-1:0]   dx_r, dy_r, dz_r, mul_a;
  logic [2*COORD_BITS-1:0] mul_ext, prod_r;
  logic [SQ_W-1:0]         sq_r;

  logic [ROOT_W-1:0] root;
  logic              root_done;
  logic [DIST_W-1:0] root_dist, dist_r;
  lod_class_t        cls_nxt, cls_r;
  logic              culled;

  // frame statistics
  logic [COUNT_BITS-1:0] total_r, culled_r, visible_r, high_r, med_r, low_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SUM_W:0]        sum_add;

  logic [PCT_NUM_W-1:0]  pct_num;
  logic [DIV_W-1:0]      div_dividend, quotient;
  logic [COUNT_BITS-1:0] div_divisor;
  logic                  div_done;
  logic [DIST_W-1:0]     avg_r;
  logic [PCT_W-1:0]      pct;

  // output word register
  logic                 out_valid_r;
  kind_t                kind_r;
  lod_class_t           lod_class_r;
  logic [DIST_W-1:0]    distance_r, average_r;
  logic [OUT_CNT_W-1:0] total_cnt_r, culled_cnt_r, visible_cnt_r;
  logic [OUT_CNT_W-1:0] high_cnt_r, medium_cnt_r, low_cnt_r;
  logic [PCT_W-1:0]     pct_r;
  logic                 last_r;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      pos_x_r   <= in_pos_x;
      pos_y_r   <= in_pos_y;
      pos_z_r   <= in_pos_z;
      present_r <= in_present;
      eof_r     <= in_eof;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_X:   mul_a = dx_r;
      MUL_Y:   mul_a = dy_r;
      MUL_Z:   mul_a = dz_r;
      default: mul_a = '0;
    endcase
  end

  assign mul_ext = {{COORD_BITS{1'b0}}, mul_a};

  always_ff @(posedge clk) begin
    if (cmd.diff_en) begin
      dx_r <= abs_diff(pos_x_r, cfg.cam_x);
      dy_r <= abs_diff(pos_y_r, cfg.cam_y);
      dz_r <= abs_diff(pos_z_r, cfg.cam_z);
      sq_r <= '0;
    end else if (cmd.acc_en) begin
      sq_r <= sq_r + SQ_W'(prod_r);
    end
    if (cmd.mul_en) begin
      prod_r <= mul_ext * mul_ext;
    end
  end

  dclc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (sq_r),
    .root     (root),
    .done     (root_done)
  );

  assign root_dist = dist_clamp(root);

  // high test wins over medium where the bands overlap
  always_comb begin
    culled  = cfg.cull_en && (root_dist > cfg.max_dist);
    cls_nxt = CLS_VISIBLE;
    if (culled) begin
      cls_nxt = CLS_CULLED;
    end else if (cfg.lod_en) begin
      if (root_dist <= cfg.high_dist) begin
        cls_nxt = CLS_HIGH;
      end else if (root_dist <= cfg.med_dist) begin
        cls_nxt = CLS_MEDIUM;
      end else begin
        cls_nxt = CLS_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      cls_r  <= cls_nxt;
      dist_r <= root_dist;
    end
  end

  assign sum_add = {1'b0, sum_r} + (SUM_W+1)'(root_dist);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.sum_write) begin
      total_r   <= '0;
      culled_r  <= '0;
      visible_r <= '0;
      high_r    <= '0;
      med_r     <= '0;
      low_r     <= '0;
      sum_r     <= '0;
    end else begin
      if (cmd.load_in) begin
        total_r <= sat_inc(total_r);
      end
      if (cmd.classify) begin
        if (cls_nxt == CLS_CULLED) begin
          culled_r <= sat_inc(culled_r);
        end else begin
          visible_r <= sat_inc(visible_r);
          sum_r     <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
          case (cls_nxt)
            CLS_HIGH:   high_r <= sat_inc(high_r);
            CLS_MEDIUM: med_r  <= sat_inc(med_r);
            CLS_LOW:    low_r  <= sat_inc(low_r);
            default: ;
          endcase
        end
      end
    end
  end

  // one shared divider: average first, then culled share
  assign pct_num      = PCT_NUM_W'(culled_r) * PCT_NUM_W'(PCT_SCALE);
  assign div_dividend = (cmd.div_sel == DIV_AVG) ? sum_r : DIV_W'(pct_num);
  assign div_divisor  = (cmd.div_sel == DIV_AVG) ? visible_r : total_r;

  dclc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.avg_capture) begin
      if (visible_r == '0) begin
        avg_r <= '0;
      end else begin
        avg_r <= (quotient > DIV_W'(DIST_MAX)) ? DIST_MAX : quotient[DIST_W-1:0];
      end
    end
  end

  always_comb begin
    if (total_r == '0) begin
      pct = '0;
    end else begin
      pct = (quotient > DIV_W'(PCT_SCALE)) ? PCT_SCALE : quotient[PCT_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.obj_write || cmd.sum_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.obj_write) begin
      kind_r        <= KIND_OBJECT;
      lod_class_r   <= cls_r;
      distance_r    <= dist_r;
      total_cnt_r   <= '0;
      culled_cnt_r  <= '0;
      visible_cnt_r <= '0;
      high_cnt_r    <= '0;
      medium_cnt_r  <= '0;
      low_cnt_r     <= '0;
      average_r     <= '0;
      pct_r         <= '0;
      last_r        <= !eof_r;
    end else if (cmd.sum_write) begin
      kind_r        <= KIND_SUMMARY;
      lod_class_r   <= CLS_VISIBLE;
      distance_r    <= '0;
      total_cnt_r   <= out_count(total_r);
      culled_cnt_r  <= out_count(culled_r);
      visible_cnt_r <= out_count(visible_r);
      high_cnt_r    <= out_count(high_r);
      medium_cnt_r  <= out_count(med_r);
      low_cnt_r     <= out_count(low_r);
      average_r     <= avg_r;
      pct_r         <= pct;
      last_r        <= 1'b1;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.kind             = kind_r;
  assign out_ch.lod_class        = lod_class_r;
  assign out_ch.distance         = distance_r;
  assign out_ch.total_count      = total_cnt_r;
  assign out_ch.culled_count     = culled_cnt_r;
  assign out_ch.visible_count    = visible_cnt_r;
  assign out_ch.high_count       = high_cnt_r;
  assign out_ch.medium_count     = medium_cnt_r;
  assign out_ch.low_count        = low_cnt_r;
  assign out_ch.average_distance = average_r;
  assign out_ch.culled_percent   = pct_r;
  assign out_ch.last             = last_r;

  always_comb begin
    status.present   = present_r;
    status.eof       = eof_r;
    status.root_done = root_done;
    status.div_done  = div_done;
    status.out_free  = out_free;
  end

  // a pending word is never overwritten
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.obj_write || cmd.sum_write, out_free)
  // summary clears the frame statistics
  `ASSERT_NEXT(a_stats_clear, clk, rst_n, cmd.sum_write, total_r == '0 && sum_r == '0)
  `ASSERT_NEXT(a_total_step, clk, rst_n, cmd.load_in && total_r != {COUNT_BITS{1'b1}},
               total_r == $past(total_r) + 1'b1)

endmodule

`default_nettype wire

[sv/dclc_ctrl.sv]
// controller: sequences each object word through the datapath, and the summary at frame end
// depends on dclc_pkg
`default_nettype none
`include "assert_macros.svh"

module dclc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dclc_pkg::dclc_status_t status,
  output dclc_pkg::dclc_cmd_t    cmd
);
  import dclc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff_en = 1'b1;
        if (status.present) begin
          state_nxt = S_MUL_X;
        end else if (status.eof) begin
          state_nxt = S_AVG_GO;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_X;
        state_nxt   = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Y;
        cmd.acc_en  = 1'b1;
        state_nxt   = S_MUL_Z;
      end
      S_MUL_Z: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_Z;
        cmd.acc_en  = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (status.root_done) begin
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_nxt    = S_EMIT_OBJ;
      end
      S_EMIT_OBJ: begin
        if (status.out_free) begin
          cmd.obj_write = 1'b1;
          state_nxt     = status.eof ? S_AVG_GO : S_IDLE;
        end
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_nxt     = S_AVG_WAIT;
      end
      S_AVG_WAIT: begin
        cmd.div_sel = DIV_AVG;
        if (status.div_done) begin
          cmd.avg_capture = 1'b1;
          state_nxt       = S_PCT_GO;
        end
      end
      S_PCT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_PCT;
        state_nxt     = S_PCT_WAIT;
      end
      S_PCT_WAIT: begin
        cmd.div_sel = DIV_PCT;
        if (status.div_done) begin
          state_nxt = S_EMIT_SUM;
        end
      end
      S_EMIT_SUM: begin
        cmd.div_sel = DIV_PCT;
        if (status.out_free) begin
          cmd.sum_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `ASSERT_NEXT(a_sum_then_idle, clk, rst_n, cmd.sum_write, state_r == S_IDLE)
  `ASSERT_NEXT(a_accept_then_diff, clk, rst_n, in_valid && in_ready, state_r == S_DIFF)

endmodule

`default_nettype wire

[sv/distance_cull_lod_classifier_top.sv]
// top level of the distance cull / lod classifier
// depends on dclc_pkg, dclc_if, dclc_regs, dclc_ctrl, dclc_dp
//
//  port     dir  handshake        word contents
//  in_ch    in   valid / ready    pos_x pos_y pos_z present end_of_frame
//  out_ch   out  valid / ready    kind lod_class distance counts average_distance
//                                 culled_percent last
//  apb      in   psel / penable   paddr pwdata prdata, pready tied high
//
// a present object's time from accept to the next accept is mostly the
// 25-step bit-serial square root plus any wait to emit; an absent object without frame end skips it
// a frame end adds two 41-step passes of the shared restoring divider
// rst_n is synchronous and active low; it clears control state and frame statistics
// a finished word waits in the output register while the next object is accepted;
// the block holds in its emit step only while that register is still occupied
`default_nettype none

module distance_cull_lod_classifier_top (
  input  logic                            clk,
  input  logic                            rst_n,
  dclc_in_if.sink                         in_ch,
  dclc_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dclc_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [dclc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dclc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dclc_pkg::*;

  dclc_cfg_t    cfg;
  dclc_cmd_t    cmd;
  dclc_status_t status;
  logic         in_ready;

  assign pready      = 1'b1;
  assign in_ch.ready = in_ready;

  dclc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  dclc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dclc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .in_pos_x   (in_ch.pos_x),
    .in_pos_y   (in_ch.pos_y),
    .in_pos_z   (in_ch.pos_z),
    .in_present (in_ch.present),
    .in_eof     (in_ch.end_of_frame),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

[bench/tb_distance_cull_lod_classifier_top.sv]
`timescale 1ns / 100ps
// self-checking bench for distance_cull_lod_classifier_top: object words in, result words out
// depends on dclc_pkg, dclc_if and the block rtl; expected words are predicted in-bench

module tb_distance_cull_lod_classifier_top;
  import dclc_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int BURST_ITEMS   = 40;
  localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;
  localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

  typedef struct packed {
    logic                 kind;
    logic [CLASS_W-1:0]   lod_class;
    logic [DIST_W-1:0]    distance;
    logic [OUT_CNT_W-1:0] total_count;
    logic [OUT_CNT_W-1:0] culled_count;
    logic [OUT_CNT_W-1:0] visible_count;
    logic [OUT_CNT_W-1:0] high_count;
    logic [OUT_CNT_W-1:0] medium_count;
    logic [OUT_CNT_W-1:0] low_count;
    logic [DIST_W-1:0]    average_distance;
    logic [PCT_W-1:0]     culled_percent;
    logic                 last;
  } cull_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dclc_in_if  in_ch ();
  dclc_out_if out_ch ();

  distance_cull_lod_classifier_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // predictor copy of the registers and of the frame statistics
  logic signed [COORD_BITS-1:0] cam_x, cam_y, cam_z;
  logic [DIST_W-1:0]            max_dist, high_dist, med_dist;
  logic                         cull_en, lod_en;
  logic [COUNT_BITS-1:0]        frame_total, frame_culled, frame_visible;
  logic [COUNT_BITS-1:0]        high_cnt, med_cnt, low_cnt;
  logic [SUM_W-1:0]             dist_sum;

  cull_result_t pending_results[$];
  int           mismatches   = 0;
  bit           no_gaps      = 1'b0;
  int           hold_request = 0;
  int           hold_left    = 0;
  int           stall_cycles = 0;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic longint unsigned abs_delta(input logic signed [COORD_BITS-1:0] a, b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // floor root, one result bit at a time from the top
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    return COORD_BITS'($urandom());
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(
      input logic signed [COORD_BITS-1:0] center, input int spread);
    longint v;
    v = longint'(center) + longint'($urandom_range(2 * spread)) - spread;
    if (v > COORD_MAX) v = COORD_MAX;
    else if (v < COORD_MIN) v = COORD_MIN;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic clear_frame_stats();
    frame_total   = '0;
    frame_culled  = '0;
    frame_visible = '0;
    high_cnt      = '0;
    med_cnt       = '0;
    low_cnt       = '0;
    dist_sum      = '0;
  endtask

  // expected words for one accepted object word
  task automatic classify_object(input logic signed [COORD_BITS-1:0] px, py, pz,
                                 input logic present, eof);
    longint unsigned dx, dy, dz, dist_wide, sum_wide, avg, pct;
    logic [DIST_W-1:0] obj_dist;
    lod_class_t        cls;
    cull_result_t      obj, summary;
    frame_total = sat_inc(frame_total);
    if (present) begin
      dx = abs_delta(px, cam_x);
      dy = abs_delta(py, cam_y);
      dz = abs_delta(pz, cam_z);
      dist_wide = int_sqrt(dx * dx + dy * dy + dz * dz);
      obj_dist = (dist_wide > DIST_MAX) ? DIST_MAX : dist_wide[DIST_W-1:0];
      if (cull_en && obj_dist > max_dist) begin
        cls = CLS_CULLED;
        frame_culled = sat_inc(frame_culled);
      end else begin
        if (!lod_en) begin
          cls = CLS_VISIBLE;
        end else if (obj_dist <= high_dist) begin
          cls = CLS_HIGH;
          high_cnt = sat_inc(high_cnt);
        end else if (obj_dist <= med_dist) begin
          cls = CLS_MEDIUM;
          med_cnt = sat_inc(med_cnt);
        end else begin
          cls = CLS_LOW;
          low_cnt = sat_inc(low_cnt);
        end
        frame_visible = sat_inc(frame_visible);
        sum_wide = dist_sum + obj_dist;
        dist_sum = (sum_wide > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum_wide[SUM_W-1:0];
      end
      obj = '0;
      obj.kind = KIND_OBJECT;
      obj.lod_class = cls;
      obj.distance = obj_dist;
      obj.last = !eof;
      pending_results.insert(pending_results.size(), obj);
    end
    if (eof) begin
      avg = (frame_visible != 0) ? dist_sum / frame_visible : 0;
      if (avg > DIST_MAX) avg = DIST_MAX;
      pct = (64'(frame_culled) * 25600) / frame_total;
      if (pct > PCT_SCALE) pct = PCT_SCALE;
      summary = '0;
      summary.kind = KIND_SUMMARY;
      summary.total_count = frame_total;
      summary.culled_count = frame_culled;
      summary.visible_count = frame_visible;
      summary.high_count = high_cnt;
      summary.medium_count = med_cnt;
      summary.low_count = low_cnt;
      summary.average_distance = avg[DIST_W-1:0];
      summary.culled_percent = pct[PCT_W-1:0];
      summary.last = 1'b1;
      pending_results.insert(pending_results.size(), summary);
      clear_frame_stats();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    cull_result_t want;
    if (pending_results.size() == 0) begin
      $error("result word with nothing expected: kind %0d, distance %0d",
             out_ch.kind, out_ch.distance);
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 64'(want.kind), 64'(out_ch.kind));
      check_field("lod_class", 64'(want.lod_class), 64'(out_ch.lod_class));
      check_field("distance", 64'(want.distance), 64'(out_ch.distance));
      check_field("total_count", 64'(want.total_count), 64'(out_ch.total_count));
      check_field("culled_count", 64'(want.culled_count), 64'(out_ch.culled_count));
      check_field("visible_count", 64'(want.visible_count), 64'(out_ch.visible_count));
      check_field("high_count", 64'(want.high_count), 64'(out_ch.high_count));
      check_field("medium_count", 64'(want.medium_count), 64'(out_ch.medium_count));
      check_field("low_count", 64'(want.low_count), 64'(out_ch.low_count));
      check_field("average_distance", 64'(want.average_distance),
                  64'(out_ch.average_distance));
      check_field("culled_percent", 64'(want.culled_percent), 64'(out_ch.culled_percent));
      check_field("last", 64'(want.last), 64'(out_ch.last));
    end
  endtask

  // result side: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request <= 0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic offer_object(input logic signed [COORD_BITS-1:0] px, py, pz,
                              input logic present, eof);
    while (!no_gaps && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.pos_x        <= px;
    in_ch.pos_y        <= py;
    in_ch.pos_z        <= pz;
    in_ch.present      <= present;
    in_ch.end_of_frame <= eof;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    classify_object(px, py, pz, present, eof);
  endtask

  task automatic await_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // an absent word may still be in flight after the last result
  task automatic settle();
    await_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back transfers keep psel high; the caller drops it
  task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAM_X:     cam_x = value[COORD_BITS-1:0];
      REG_CAM_Y:     cam_y = value[COORD_BITS-1:0];
      REG_CAM_Z:     cam_z = value[COORD_BITS-1:0];
      REG_MAX_DIST:  max_dist = value[DIST_W-1:0];
      REG_HIGH_DIST: high_dist = value[DIST_W-1:0];
      REG_MED_DIST:  med_dist = value[DIST_W-1:0];
      REG_CULL_EN:   cull_en = value[0];
      REG_LOD_EN:    lod_en = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic signed [COORD_BITS-1:0] cx, cy, cz,
                           input logic [DIST_W-1:0] maxd, highd, medd,
                           input logic cull, lod);
    settle();
    write_reg(REG_CAM_X, APB_DATA_W'(cx));
    write_reg(REG_CAM_Y, APB_DATA_W'(cy));
    write_reg(REG_CAM_Z, APB_DATA_W'(cz));
    write_reg(REG_MAX_DIST, APB_DATA_W'(maxd));
    write_reg(REG_HIGH_DIST, APB_DATA_W'(highd));
    write_reg(REG_MED_DIST, APB_DATA_W'(medd));
    write_reg(REG_CULL_EN, APB_DATA_W'(cull));
    write_reg(REG_LOD_EN, APB_DATA_W'(lod));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // reset values: camera at origin, no cull limit, zero bands
  task automatic test_reset_state();
    offer_object(0, 0, 0, 1'b1, 1'b0);
    offer_object(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    offer_object(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    offer_object(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
    offer_object(0, 0, 256, 1'b1, 1'b1);
  endtask

  // objects on the axes, exactly on and just past each threshold
  task automatic test_band_edges();
    configure(1000, -2000, 3000, 5000, 1000, 3000, 1'b1, 1'b1);
    offer_object(COORD_BITS'(cam_x + 1000), cam_y, cam_z, 1'b1, 1'b0);
    offer_object(cam_x, COORD_BITS'(cam_y - 1001), cam_z, 1'b1, 1'b0);
    offer_object(cam_x, cam_y, COORD_BITS'(cam_z + 3000), 1'b1, 1'b0);
    offer_object(cam_x, cam_y, COORD_BITS'(cam_z - 3001), 1'b1, 1'b0);
    offer_object(COORD_BITS'(cam_x + 5000), cam_y, cam_z, 1'b1, 1'b0);
    offer_object(cam_x, COORD_BITS'(cam_y + 5001), cam_z, 1'b1, 1'b0);
    offer_object(COORD_BITS'(cam_x - 5001), cam_y, cam_z, 1'b1, 1'b1);
    // frame of one absent slot: nothing visible, nothing culled
    offer_object(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b1);
  endtask

  task automatic test_band_overlap_and_enables();
    // medium below high, culling off with a zero limit
    configure(0, 0, 0, 0, 4000, 2000, 1'b0, 1'b1);
    offer_object(3000, 0, 0, 1'b1, 1'b0);
    offer_object(0, 4001, 0, 1'b1, 1'b0);
    offer_object(0, 0, -1000, 1'b1, 1'b1);
    configure(0, 0, 0, 5000, 4000, 2000, 1'b1, 1'b0);
    offer_object(4000, 0, 0, 1'b1, 1'b0);
    offer_object(0, -6000, 0, 1'b1, 1'b0);
    offer_object(0, 0, 0, 1'b0, 1'b1);
    // everything culled
    configure(0, 0, 0, 0, 0, 0, 1'b1, 1'b1);
    offer_object(1, 0, 0, 1'b1, 1'b0);
    offer_object(0, 0, -1, 1'b1, 1'b1);
  endtask

  task automatic test_camera_extremes();
    configure(COORD_MIN, COORD_MAX, COORD_MIN, DIST_MAX, DIST_MAX, '0, 1'b1, 1'b1);
    offer_object(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
    offer_object(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
    offer_object(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b1);
  endtask

  // result side stalls while words keep coming, so the input backs up
  task automatic test_output_hold_off();
    configure(0, 0, 0, 20000, 5000, 10000, 1'b1, 1'b1);
    hold_request <= HOLD_CYCLES;
    for (int i = 0; i < 12; i++)
      offer_object(near_coord(0, 16000), near_coord(0, 16000), near_coord(0, 16000),
                   1'b1, i % 4 == 3);
  endtask

  // back-to-back absent slots, then one culled object closes the frame
  task automatic test_absent_burst();
    configure(0, 0, 0, 100, 0, 0, 1'b1, 1'b1);
    no_gaps <= 1'b1;
    repeat (BURST_ITEMS) offer_object(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
    offer_object(0, 0, 4096, 1'b1, 1'b1);
    no_gaps <= 1'b0;
  endtask

  task automatic test_random_frames();
    int spread, phase_items, frame_len;
    logic signed [COORD_BITS-1:0] cx, cy, cz;
    logic [DIST_W-1:0] maxd, highd, medd;
    logic present;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(2))
        0:       spread = 1000;
        1:       spread = 200000;
        default: spread = 8388607;
      endcase
      cx = rand_coord();
      cy = rand_coord();
      cz = rand_coord();
      maxd = DIST_W'($urandom_range(2 * spread));
      highd = DIST_W'($urandom_range(spread));
      medd = DIST_W'($urandom_range(2 * spread));
      if (phase == 0) begin
        maxd = DIST_MAX;
        highd = DIST_MAX;
        medd = DIST_MAX;
      end else if (phase == 1) begin
        maxd = '0;
        highd = '0;
        medd = '0;
      end
      configure(cx, cy, cz, maxd, highd, medd,
                $urandom_range(3) != 0, $urandom_range(3) != 0);
      no_gaps <= (phase == 4);
      phase_items = 0;
      while (phase_items < 56) begin
        frame_len = $urandom_range(12, 1);
        for (int i = 1; i <= frame_len; i++) begin
          present = $urandom_range(99) < 85;
          if ($urandom_range(99) < 20)
            offer_object(rand_coord(), rand_coord(), rand_coord(), present, i == frame_len);
          else
            offer_object(near_coord(cx, spread), near_coord(cy, spread),
                         near_coord(cz, spread), present, i == frame_len);
        end
        phase_items += frame_len;
        if ($urandom_range(99) < 15) await_results();
      end
    end
    no_gaps <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.pos_x        = '0;
    in_ch.pos_y        = '0;
    in_ch.pos_z        = '0;
    in_ch.present      = 1'b0;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cam_x              = '0;
    cam_y              = '0;
    cam_z              = '0;
    max_dist           = DIST_MAX;
    high_dist          = '0;
    med_dist           = '0;
    cull_en            = 1'b1;
    lod_en             = 1'b1;
    clear_frame_stats();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_band_edges();
    test_band_overlap_and_enables();
    test_camera_extremes();
    test_output_hold_off();
    test_absent_burst();
    test_random_frames();

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/dclc_pkg.sv
sv/dclc_if.sv
sv/dclc_regs.sv
sv/dclc_sqrt.sv
sv/dclc_div.sv
sv/dclc_dp.sv
sv/dclc_ctrl.sv
sv/distance_cull_lod_classifier_top.sv
bench/tb_distance_cull_lod_classifier_top.sv
